[design/mwf_pkg.sv]
package mwf_pkg;

  localparam int MAZE_SIDE = 12;
  localparam int IDX_W     = 4;
  localparam int ROW_W     = MAZE_SIDE;
  localparam int HEAD_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;

  localparam logic [IDX_W-1:0] SIDE_IDX = IDX_W'(MAZE_SIDE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAZE_SIDE - 1);

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP    = 2'd2;

  // ST_ACK doubles as the "walk not finished" mark in the final status register.
  localparam logic [STATUS_W-1:0] ST_ACK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXITED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HOME    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd4;

  localparam logic [HEAD_W-1:0] DIR_DOWN  = 2'd0;
  localparam logic [HEAD_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [HEAD_W-1:0] DIR_UP    = 2'd2;
  localparam logic [HEAD_W-1:0] DIR_LEFT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;

  localparam logic [IDX_W-1:0]  START_ROW_RST     = 4'd2;
  localparam logic [IDX_W-1:0]  START_COL_RST     = 4'd0;
  localparam logic [HEAD_W-1:0] START_HEADING_RST = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_walls;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    pos_row;
    logic [IDX_W-1:0]    pos_col;
    logic [HEAD_W-1:0]   heading;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [HEAD_W-1:0] heading;
  } start_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] row;
    logic [ROW_W-1:0] walls;
  } wall_wr_t;

endpackage

[design/mwf_stream_if.sv]
interface mwf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/mwf_maze_store.sv]
module mwf_maze_store (
  input  logic                        clk,
  input  mwf_pkg::wall_wr_t           wr,
  input  logic [mwf_pkg::IDX_W-1:0]   row_addr,
  input  logic [mwf_pkg::IDX_W-1:0]   col_addr,
  output logic [mwf_pkg::ROW_W-1:0]   row_bits,
  output logic [mwf_pkg::ROW_W-1:0]   col_bits
);

  // The maze is kept twice: row-major for left/right neighbors and
  // column-major for up/down neighbors, so each copy is read at one address.
  logic [mwf_pkg::ROW_W-1:0] rows [mwf_pkg::MAZE_SIDE];
  logic [mwf_pkg::ROW_W-1:0] cols [mwf_pkg::MAZE_SIDE];

  always_ff @(posedge clk) begin
    if (wr.load) begin
      rows[wr.row] <= wr.walls;
      for (int c = 0; c < mwf_pkg::MAZE_SIDE; c++) begin
        cols[c][wr.row] <= wr.walls[c];
      end
    end
  end

  always_comb begin
    row_bits = '1;
    col_bits = '1;
    if (row_addr < mwf_pkg::SIDE_IDX) begin
      row_bits = rows[row_addr];
    end
    if (col_addr < mwf_pkg::SIDE_IDX) begin
      col_bits = cols[col_addr];
    end
  end

endmodule

[design/mwf_walker.sv]
module mwf_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  mwf_pkg::req_t               item,
  input  mwf_pkg::start_t             start,
  input  logic [mwf_pkg::ROW_W-1:0]   row_bits,
  input  logic [mwf_pkg::ROW_W-1:0]   col_bits,
  output logic [mwf_pkg::IDX_W-1:0]   pos_row,
  output logic [mwf_pkg::IDX_W-1:0]   pos_col,
  output mwf_pkg::rsp_t               result
);

  logic [mwf_pkg::HEAD_W-1:0]   heading;
  logic [mwf_pkg::STATUS_W-1:0] final_status;

  logic [mwf_pkg::IDX_W-1:0]    pos_row_next;
  logic [mwf_pkg::IDX_W-1:0]    pos_col_next;
  logic [mwf_pkg::HEAD_W-1:0]   heading_next;
  logic [mwf_pkg::STATUS_W-1:0] final_status_next;

  logic [mwf_pkg::IDX_W:0]   down_idx;
  logic [mwf_pkg::IDX_W:0]   right_idx;
  logic [mwf_pkg::IDX_W-1:0] up_idx;
  logic [mwf_pkg::IDX_W-1:0] left_idx;
  logic                      row_ok;
  logic                      col_ok;
  logic [3:0]                open_dir;

  assign row_ok    = pos_row < mwf_pkg::SIDE_IDX;
  assign col_ok    = pos_col < mwf_pkg::SIDE_IDX;
  assign down_idx  = {1'b0, pos_row} + 1'b1;
  assign right_idx = {1'b0, pos_col} + 1'b1;
  assign up_idx    = pos_row - 1'b1;
  assign left_idx  = pos_col - 1'b1;

  // A walker placed outside the maze can still step into it along one axis.
  always_comb begin
    open_dir[mwf_pkg::DIR_DOWN] = col_ok && (down_idx < {1'b0, mwf_pkg::SIDE_IDX}) &&
                                  !col_bits[down_idx[mwf_pkg::IDX_W-1:0]];
    open_dir[mwf_pkg::DIR_RIGHT] = row_ok && (right_idx < {1'b0, mwf_pkg::SIDE_IDX}) &&
                                   !row_bits[right_idx[mwf_pkg::IDX_W-1:0]];
    open_dir[mwf_pkg::DIR_UP] = col_ok && (pos_row != '0) &&
                                (up_idx < mwf_pkg::SIDE_IDX) && !col_bits[up_idx];
    open_dir[mwf_pkg::DIR_LEFT] = row_ok && (pos_col != '0) &&
                                  (left_idx < mwf_pkg::SIDE_IDX) && !row_bits[left_idx];
  end

  always_comb begin
    logic                         found;
    logic [mwf_pkg::HEAD_W-1:0]   dir;
    logic [mwf_pkg::HEAD_W-1:0]   mv_dir;
    logic [mwf_pkg::IDX_W-1:0]    nr;
    logic [mwf_pkg::IDX_W-1:0]    nc;
    logic                         at_start;
    logic                         at_edge;
    logic [mwf_pkg::STATUS_W-1:0] st;

    found  = 1'b0;
    mv_dir = heading;
    for (int k = 0; k < 4; k++) begin
      dir = heading + mwf_pkg::HEAD_W'(k);
      if (!found && open_dir[dir]) begin
        found  = 1'b1;
        mv_dir = dir;
      end
    end

    nr = pos_row;
    nc = pos_col;
    case (mv_dir)
      mwf_pkg::DIR_DOWN:  nr = pos_row + 1'b1;
      mwf_pkg::DIR_RIGHT: nc = pos_col + 1'b1;
      mwf_pkg::DIR_UP:    nr = up_idx;
      default:            nc = left_idx;
    endcase
    at_start = (nr == start.row) && (nc == start.col);
    at_edge  = (nr == '0) || (nr == mwf_pkg::LAST_IDX) ||
               (nc == '0) || (nc == mwf_pkg::LAST_IDX);

    pos_row_next      = pos_row;
    pos_col_next      = pos_col;
    heading_next      = heading;
    final_status_next = final_status;
    st                = mwf_pkg::ST_ACK;

    case (item.opcode)
      mwf_pkg::OP_RESTART: begin
        pos_row_next      = start.row;
        pos_col_next      = start.col;
        heading_next      = start.heading;
        final_status_next = mwf_pkg::ST_ACK;
      end
      mwf_pkg::OP_STEP: begin
        if (final_status != mwf_pkg::ST_ACK) begin
          st = final_status;
        end else if (found) begin
          pos_row_next = nr;
          pos_col_next = nc;
          heading_next = mv_dir + 2'd3;
          if (at_edge && !at_start) begin
            st                = mwf_pkg::ST_EXITED;
            final_status_next = mwf_pkg::ST_EXITED;
          end else if (at_start) begin
            st                = mwf_pkg::ST_HOME;
            final_status_next = mwf_pkg::ST_HOME;
          end else begin
            st = mwf_pkg::ST_MOVED;
          end
        end else begin
          st                = mwf_pkg::ST_BLOCKED;
          final_status_next = mwf_pkg::ST_BLOCKED;
        end
      end
      default: begin
      end
    endcase

    result.pos_row = pos_row_next;
    result.pos_col = pos_col_next;
    result.heading = heading_next;
    result.status  = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_row      <= '0;
      pos_col      <= '0;
      heading      <= '0;
      final_status <= mwf_pkg::ST_ACK;
    end else if (go) begin
      pos_row      <= pos_row_next;
      pos_col      <= pos_col_next;
      heading      <= heading_next;
      final_status <= final_status_next;
    end
  end

endmodule

[design/maze_wall_follower.sv]
// Channel  Dir  Payload                                   Transfer when
// req      in   opcode, row_index, row_walls              req.valid && req.ready
// rsp      out  pos_row, pos_col, heading, status         rsp.valid && rsp.ready
// cfg      in   cfg_index, cfg_data                       cfg_wr_en
//
// One item is taken per cycle while rsp is not stalled. Each item passes through the
// input register and then the result register, with the wall lookup and the step
// decision in one pass between them.
// rst is synchronous and active high; it restores the start registers and puts the
// walker at row 0, column 0, heading down. Maze contents are not cleared.
// A stalled rsp holds its result; req.ready drops only when both registers are full.
module maze_wall_follower (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwf_pkg::CFG_W-1:0]       cfg_data,
  mwf_stream_if.sink                      req,
  mwf_stream_if.source                    rsp
);

  mwf_pkg::start_t            start;
  logic                       hold_valid;
  mwf_pkg::req_t              hold;
  logic                       out_valid;
  mwf_pkg::rsp_t              out_data;
  logic                       out_free;
  logic                       go;
  mwf_pkg::wall_wr_t          wall_wr;
  mwf_pkg::rsp_t              result;
  logic [mwf_pkg::IDX_W-1:0]  pos_row;
  logic [mwf_pkg::IDX_W-1:0]  pos_col;
  logic [mwf_pkg::ROW_W-1:0]  row_bits;
  logic [mwf_pkg::ROW_W-1:0]  col_bits;

  assign out_free  = !out_valid || rsp.ready;
  assign go        = hold_valid && out_free;
  assign req.ready = !hold_valid || out_free;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign wall_wr.load  = go && (hold.opcode == mwf_pkg::OP_LOAD) &&
                         (hold.row_index < mwf_pkg::SIDE_IDX);
  assign wall_wr.row   = hold.row_index;
  assign wall_wr.walls = hold.row_walls;

  always_ff @(posedge clk) begin
    if (rst) begin
      start.row     <= mwf_pkg::START_ROW_RST;
      start.col     <= mwf_pkg::START_COL_RST;
      start.heading <= mwf_pkg::START_HEADING_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mwf_pkg::CFG_START_ROW:     start.row     <= cfg_data;
        mwf_pkg::CFG_START_COL:     start.col     <= cfg_data;
        mwf_pkg::CFG_START_HEADING: start.heading <= cfg_data[mwf_pkg::HEAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        hold_valid <= 1'b1;
      end else if (go) begin
        hold_valid <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold <= req.data;
    end
    if (go) begin
      out_data <= result;
    end
  end

  mwf_maze_store u_store (
    .clk      (clk),
    .wr       (wall_wr),
    .row_addr (pos_row),
    .col_addr (pos_col),
    .row_bits (row_bits),
    .col_bits (col_bits)
  );

  mwf_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .item     (hold),
    .start    (start),
    .row_bits (row_bits),
    .col_bits (col_bits),
    .pos_row  (pos_row),
    .pos_col  (pos_col),
    .result   (result)
  );

endmodule

[design/mwf_checker.sv]
module mwf_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  mwf_pkg::rsp_t rsp_data
);

  // Items taken in but whose results have not yet been transferred out.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_holds_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_holds_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("rsp payload changed while stalled");

  a_no_result_without_item: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result shown with no item in flight");

  a_two_in_flight_max: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items in flight");

  a_reset_clears_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid after reset");

endmodule

bind maze_wall_follower mwf_checker u_mwf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
